>>> hdl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int DIVISOR_WIDTH = 12;

    // stream word layout
    localparam int OPCODE_WIDTH  = 2;
    localparam int SEL_WIDTH     = 3;
    localparam int DATA_WIDTH    = 32;
    localparam int S_TDATA_WIDTH = ((SEL_WIDTH + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((DATA_WIDTH + 2 + 7) / 8) * 8;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [SEL_WIDTH-1:0] {
        REG_CTL    = 3'd0,
        REG_RANGE  = 3'd1,
        REG_DATA   = 3'd2,
        REG_CLKCTL = 3'd3,
        REG_CLKDIV = 3'd4,
        REG_UNK5   = 3'd5,
        REG_UNK6   = 3'd6,
        REG_UNK7   = 3'd7
    } reg_sel_t;

    localparam logic [7:0] PASSWORD = 8'h5A;

    localparam int CTL_PWEN_BIT = 0;
    localparam int CTL_MSEN_BIT = 7;
    localparam int CLK_ENAB_BIT = 4;
    localparam int CLK_KILL_BIT = 5;
    localparam int CLK_BUSY_BIT = 7;
    localparam int CLK_CTL_BITS = 6;
    localparam int DIV_SHIFT    = 12;

endpackage

>>> hdl/mark_space_pwm_with_clock_divider.sv
`timescale 1ns / 1ps

// Mark-space PWM channel with an integer clock divider.
// Input stream (s_*): one word per operation. tuser carries the opcode (tick of
// the source clock, register read, register write); tdata carries the register
// number and the 32-bit write value. Output stream (m_*): exactly one word per
// input word, in order, holding the read value (zero unless a read), the pin
// level after the operation and the password-rejected flag.
// The state is updated and the result registered at the edge that accepts the
// word. Throughput is one word per cycle, set by the single result register:
// s_tready stays high while that register is empty or being taken, so a tick
// can be fed every cycle.
// When the receiver stalls, the result is held and s_tready drops until it is
// taken; no word is lost.
// Reset clears all but the result payload registers: channel disabled,
// clock disabled and stopped, counters at zero, output stream empty.
module mark_space_pwm_with_clock_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] reg_select, [34:3] write_data, [39:35] zero
    input  logic [msp_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // [1:0] opcode
    input  logic [msp_pkg::OPCODE_WIDTH-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_data, [32] pwm_level, [33] password_rejected, [39:34] zero
    output logic [msp_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int CW = msp_pkg::COUNT_WIDTH;
    localparam int DW = msp_pkg::DIVISOR_WIDTH;

    logic                         en_reg, en_next;
    logic                         ms_reg, ms_next;
    logic [CW-1:0]                range_reg, range_next;
    logic [CW-1:0]                duty_reg, duty_next;
    logic [msp_pkg::CLK_CTL_BITS-1:0] clkctl_reg, clkctl_next;
    logic [DW-1:0]                div_reg, div_next;
    logic [DW-1:0]                pre_reg, pre_next;
    logic [CW-1:0]                cnt_reg, cnt_next;

    logic                         out_valid_reg;
    logic [msp_pkg::DATA_WIDTH-1:0] rd_reg, rd_next;
    logic                         level_reg, level_next;
    logic                         rej_reg, rej_next;

    msp_pkg::opcode_t             op;
    msp_pkg::reg_sel_t            sel;
    logic [msp_pkg::DATA_WIDTH-1:0] wdata;
    logic                         accept;
    logic                         pass_ok;
    logic                         running;
    logic                         running_next;
    logic                         active_next;
    logic                         pulse;
    logic [DW:0]                  pre_inc;
    logic [CW:0]                  cnt_inc;

    assign op     = msp_pkg::opcode_t'(s_tuser);
    assign sel    = msp_pkg::reg_sel_t'(s_tdata[msp_pkg::SEL_WIDTH-1:0]);
    assign wdata  = s_tdata[msp_pkg::SEL_WIDTH +: msp_pkg::DATA_WIDTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pass_ok = (wdata[31:24] == msp_pkg::PASSWORD);
    assign running = clkctl_reg[msp_pkg::CLK_ENAB_BIT] && !clkctl_reg[msp_pkg::CLK_KILL_BIT]
                     && (div_reg >= DW'(2));
    assign running_next = clkctl_next[msp_pkg::CLK_ENAB_BIT]
                          && !clkctl_next[msp_pkg::CLK_KILL_BIT]
                          && (div_next >= DW'(2));
    assign active_next = en_next && ms_next;

    assign pre_inc = {1'b0, pre_reg} + (DW+1)'(1);
    assign cnt_inc = {1'b0, cnt_reg} + (CW+1)'(1);

    always_comb
    begin
        en_next     = en_reg;
        ms_next     = ms_reg;
        range_next  = range_reg;
        duty_next   = duty_reg;
        clkctl_next = clkctl_reg;
        div_next    = div_reg;
        pre_next    = pre_reg;
        cnt_next    = cnt_reg;
        rd_next     = '0;
        rej_next    = 1'b0;
        pulse       = 1'b0;

        case (op)
            msp_pkg::OP_TICK:
            begin
                if (!running)
                begin
                    pre_next = '0;
                end
                else if (pre_inc >= {1'b0, div_reg})
                begin
                    pre_next = '0;
                    pulse    = 1'b1;
                end
                else
                begin
                    pre_next = pre_inc[DW-1:0];
                end
                if (!(en_reg && ms_reg))
                begin
                    cnt_next = '0;
                end
                else if (pulse)
                begin
                    cnt_next = (cnt_inc >= {1'b0, range_reg}) ? '0 : cnt_inc[CW-1:0];
                end
            end
            msp_pkg::OP_READ:
            begin
                case (sel)
                    msp_pkg::REG_CTL:
                    begin
                        rd_next[msp_pkg::CTL_PWEN_BIT] = en_reg;
                        rd_next[msp_pkg::CTL_MSEN_BIT] = ms_reg;
                    end
                    msp_pkg::REG_RANGE:  rd_next = 32'(range_reg);
                    msp_pkg::REG_DATA:   rd_next = 32'(duty_reg);
                    msp_pkg::REG_CLKCTL:
                    begin
                        rd_next = 32'(clkctl_reg);
                        rd_next[msp_pkg::CLK_BUSY_BIT] = running;
                    end
                    msp_pkg::REG_CLKDIV: rd_next = 32'(div_reg) << msp_pkg::DIV_SHIFT;
                    default:             rd_next = '0;
                endcase
            end
            msp_pkg::OP_WRITE:
            begin
                case (sel)
                    msp_pkg::REG_CTL:
                    begin
                        en_next = wdata[msp_pkg::CTL_PWEN_BIT];
                        ms_next = wdata[msp_pkg::CTL_MSEN_BIT];
                        if (!(en_next && ms_next))
                        begin
                            cnt_next = '0;
                        end
                    end
                    msp_pkg::REG_RANGE: range_next = wdata[CW-1:0];
                    msp_pkg::REG_DATA:  duty_next  = wdata[CW-1:0];
                    msp_pkg::REG_CLKCTL:
                    begin
                        if (!pass_ok)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            clkctl_next = wdata[msp_pkg::CLK_CTL_BITS-1:0];
                            if (!running_next)
                            begin
                                pre_next = '0;
                            end
                        end
                    end
                    msp_pkg::REG_CLKDIV:
                    begin
                        if (!pass_ok)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            div_next = wdata[msp_pkg::DIV_SHIFT +: DW];
                            if (!running_next)
                            begin
                                pre_next = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        level_next = active_next && (cnt_next < duty_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            ms_reg        <= 1'b0;
            range_reg     <= '0;
            duty_reg      <= '0;
            clkctl_reg    <= '0;
            div_reg       <= '0;
            pre_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                en_reg     <= en_next;
                ms_reg     <= ms_next;
                range_reg  <= range_next;
                duty_reg   <= duty_next;
                clkctl_reg <= clkctl_next;
                div_reg    <= div_next;
                pre_reg    <= pre_next;
                cnt_reg    <= cnt_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_next;
            level_reg <= level_next;
            rej_reg   <= rej_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = msp_pkg::M_TDATA_WIDTH'({rej_reg, level_reg, rd_reg});

    // counter is parked at zero unless enabled in mark-space mode
    a_cnt_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !(en_reg && ms_reg) |-> (cnt_reg == '0))
        else $error("period counter running with channel inactive");

    // prescaler is parked at zero whenever the clock is stopped
    a_pre_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !running |-> (pre_reg == '0))
        else $error("prescaler running with clock stopped");

    // every accepted word leaves a result behind
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    // a rejected write never carries read data
    a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && rej_reg) |-> (rd_reg == '0))
        else $error("rejected write with read data");

endmodule

>>> tb/tb_mark_space_pwm_with_clock_divider.sv
`timescale 1ns / 1ps

module tb_mark_space_pwm_with_clock_divider;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 550;
    localparam int TAIL_CYCLES  = 4;

    typedef struct packed {
        msp_pkg::opcode_t                op;
        msp_pkg::reg_sel_t               sel;
        logic [msp_pkg::DATA_WIDTH-1:0]  wdata;
    } pwm_op_t;

    typedef struct packed {
        logic [msp_pkg::DATA_WIDTH-1:0]  rdata;
        logic                            level;
        logic                            rejected;
    } pwm_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [msp_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic [msp_pkg::OPCODE_WIDTH-1:0]  s_tuser = msp_pkg::OP_NOP;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [msp_pkg::M_TDATA_WIDTH-1:0] m_tdata;

    pwm_op_t     pending_ops[$];
    pwm_result_t expected_words[$];
    pwm_op_t     presented_op;
    int          n_accepted = 0;
    int          n_errors = 0;
    int          n_total = 0;
    int          n_cycles = 0;
    int          send_idle_pct = 7;
    int          recv_idle_pct = 48;

    // shadow copy of the block's state
    logic                              pwen;
    logic                              msen;
    logic [msp_pkg::COUNT_WIDTH-1:0]   range_reg;
    logic [msp_pkg::COUNT_WIDTH-1:0]   duty_reg;
    logic [msp_pkg::CLK_CTL_BITS-1:0]  clkctl_reg;
    logic [msp_pkg::DIVISOR_WIDTH-1:0] div_reg;
    logic [msp_pkg::DIVISOR_WIDTH-1:0] prescale;
    logic [msp_pkg::COUNT_WIDTH-1:0]   period_cnt;

    mark_space_pwm_with_clock_divider dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic clk_running();
        return clkctl_reg[msp_pkg::CLK_ENAB_BIT] && !clkctl_reg[msp_pkg::CLK_KILL_BIT]
               && div_reg >= 2;
    endfunction

    function automatic logic pwm_pin();
        if (!(pwen && msen))
            return 1'b0;
        return period_cnt < duty_reg;
    endfunction

    // advances the shadow state by one word and gives the word the block should return
    function automatic pwm_result_t pwm_step(pwm_op_t w);
        pwm_result_t                      r;
        logic                             pulse;
        logic                             pass_ok;
        logic [msp_pkg::COUNT_WIDTH:0]    nxt;
        r = '0;
        pulse = 1'b0;
        pass_ok = (w.wdata[31:24] == msp_pkg::PASSWORD);
        case (w.op)
            msp_pkg::OP_TICK:
            begin
                if (!clk_running())
                    prescale = '0;
                else if ({1'b0, prescale} + 1 >= {1'b0, div_reg})
                begin
                    prescale = '0;
                    pulse = 1'b1;
                end
                else
                    prescale = prescale + 1'b1;
                if (!(pwen && msen))
                    period_cnt = '0;
                else if (pulse)
                begin
                    nxt = {1'b0, period_cnt} + 1'b1;
                    period_cnt = (nxt >= {1'b0, range_reg}) ? '0
                                 : nxt[msp_pkg::COUNT_WIDTH-1:0];
                end
            end
            msp_pkg::OP_READ:
                case (w.sel)
                    msp_pkg::REG_CTL:
                    begin
                        r.rdata[msp_pkg::CTL_PWEN_BIT] = pwen;
                        r.rdata[msp_pkg::CTL_MSEN_BIT] = msen;
                    end
                    msp_pkg::REG_RANGE:  r.rdata = range_reg;
                    msp_pkg::REG_DATA:   r.rdata = duty_reg;
                    msp_pkg::REG_CLKCTL:
                    begin
                        r.rdata[msp_pkg::CLK_CTL_BITS-1:0] = clkctl_reg;
                        r.rdata[msp_pkg::CLK_BUSY_BIT] = clk_running();
                    end
                    msp_pkg::REG_CLKDIV:
                        r.rdata[msp_pkg::DIV_SHIFT +: msp_pkg::DIVISOR_WIDTH] = div_reg;
                    default:    r.rdata = '0;
                endcase
            msp_pkg::OP_WRITE:
                case (w.sel)
                    msp_pkg::REG_CTL:
                    begin
                        pwen = w.wdata[msp_pkg::CTL_PWEN_BIT];
                        msen = w.wdata[msp_pkg::CTL_MSEN_BIT];
                        if (!(pwen && msen))
                            period_cnt = '0;
                    end
                    msp_pkg::REG_RANGE: range_reg = w.wdata[msp_pkg::COUNT_WIDTH-1:0];
                    msp_pkg::REG_DATA:  duty_reg = w.wdata[msp_pkg::COUNT_WIDTH-1:0];
                    msp_pkg::REG_CLKCTL, msp_pkg::REG_CLKDIV:
                    begin
                        if (!pass_ok)
                            r.rejected = 1'b1;
                        else
                        begin
                            if (w.sel == msp_pkg::REG_CLKCTL)
                                clkctl_reg = w.wdata[msp_pkg::CLK_CTL_BITS-1:0];
                            else
                                div_reg = w.wdata[msp_pkg::DIV_SHIFT +:
                                                  msp_pkg::DIVISOR_WIDTH];
                            if (!clk_running())
                                prescale = '0;
                        end
                    end
                    default: ;
                endcase
            default: ;
        endcase
        r.level = pwm_pin();
        return r;
    endfunction

    task automatic add_op(msp_pkg::opcode_t op, msp_pkg::reg_sel_t sel,
                          logic [msp_pkg::DATA_WIDTH-1:0] d);
        pwm_op_t w;
        w.op = op;
        w.sel = sel;
        w.wdata = d;
        pending_ops.push_back(w);
        n_total++;
    endtask

    function automatic logic [msp_pkg::DATA_WIDTH-1:0] with_password(logic [23:0] low);
        return {msp_pkg::PASSWORD, low};
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_words.push_back(pwm_step(presented_op));
                n_accepted++;
            end
            if (n_accepted < n_total / 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 48;
            end
            else if (n_accepted < (2 * n_total) / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    presented_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(msp_pkg::S_TDATA_WIDTH - msp_pkg::SEL_WIDTH
                                  - msp_pkg::DATA_WIDTH){1'b0}},
                                presented_op.wdata, presented_op.sel};
                    s_tuser <= presented_op.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_result
        pwm_result_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word %h with nothing expected", m_tdata);
                n_errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_tdata[31:0] !== exp_w.rdata)
                begin
                    $error("read_data: expected %h, got %h", exp_w.rdata, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[32] !== exp_w.level)
                begin
                    $error("pwm_level: expected %b, got %b", exp_w.level, m_tdata[32]);
                    n_errors++;
                end
                if (m_tdata[33] !== exp_w.rejected)
                begin
                    $error("password_rejected: expected %b, got %b", exp_w.rejected,
                           m_tdata[33]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [msp_pkg::DATA_WIDTH-1:0] d;
        int                             n_ticks;
        int                             pick;

        pwen = 1'b0;
        msen = 1'b0;
        range_reg = '0;
        duty_reg = '0;
        clkctl_reg = '0;
        div_reg = '0;
        prescale = '0;
        period_cnt = '0;

        // reset values, unknown registers, unknown opcode
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CTL, '0);
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CLKCTL, '0);
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CLKDIV, '0);
        add_op(msp_pkg::OP_READ, msp_pkg::REG_UNK5, 32'hFFFF_FFFF);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_UNK6, 32'hFFFF_FFFF);
        add_op(msp_pkg::OP_READ, msp_pkg::REG_UNK7, '0);
        add_op(msp_pkg::OP_NOP, msp_pkg::REG_UNK7, 32'hFFFF_FFFF);
        add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);
        // clock writes without password are refused
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKCTL, 32'hA5FF_FFFF);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKDIV, 32'h0000_0000);
        // divisor of one keeps the clock stopped; fraction bits dropped
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKCTL, with_password(24'h00_001F));
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKDIV, with_password(24'h00_1FFF));
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CLKCTL, '0);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKDIV, with_password(24'h00_2000));
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CTL, 32'hFFFF_FFFF);
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CTL, '0);
        // zero range with non-zero duty: pin high
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_DATA, 32'd1);
        add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);
        add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);
        // duty above range: pin stays high
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_RANGE, 32'd3);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_DATA, 32'hFFFF_FFFF);
        add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_DATA, 32'd2);
        repeat (6) add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);
        // kill stops the clock, then largest divisor
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKCTL, with_password(24'h00_0030));
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CLKCTL, '0);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKDIV, with_password(24'hFF_F000));
        add_op(msp_pkg::OP_READ, msp_pkg::REG_CLKDIV, '0);
        add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CTL, '0);
        add_op(msp_pkg::OP_TICK, msp_pkg::REG_CTL, '0);

        while (n_total < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                // set the channel up, then let it run
                if ($urandom_range(0, 3) != 0)
                begin
                    d = $urandom;
                    d[msp_pkg::CTL_PWEN_BIT] = ($urandom_range(0, 9) != 0);
                    d[msp_pkg::CTL_MSEN_BIT] = ($urandom_range(0, 9) != 0);
                    add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CTL, d);
                end
                if ($urandom_range(0, 2) != 0)
                    add_op(msp_pkg::OP_WRITE, msp_pkg::REG_RANGE,
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 10));
                if ($urandom_range(0, 2) != 0)
                    add_op(msp_pkg::OP_WRITE, msp_pkg::REG_DATA,
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12));
                if ($urandom_range(0, 2) != 0)
                begin
                    d = $urandom;
                    if ($urandom_range(0, 9) != 0)
                        d[31:24] = msp_pkg::PASSWORD;
                    d[msp_pkg::CLK_ENAB_BIT] = ($urandom_range(0, 7) != 0);
                    d[msp_pkg::CLK_KILL_BIT] = ($urandom_range(0, 7) == 0);
                    add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKCTL, d);
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    d = $urandom;
                    if ($urandom_range(0, 9) != 0)
                        d[31:24] = msp_pkg::PASSWORD;
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        d[msp_pkg::DIV_SHIFT +: msp_pkg::DIVISOR_WIDTH] = '1;
                    else if (pick > 1)
                        d[msp_pkg::DIV_SHIFT +: msp_pkg::DIVISOR_WIDTH] = $urandom_range(0, 5);
                    add_op(msp_pkg::OP_WRITE, msp_pkg::REG_CLKDIV, d);
                end
                n_ticks = $urandom_range(8, 40);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_op(msp_pkg::OP_READ,
                               msp_pkg::reg_sel_t'($urandom_range(0, 7)), $urandom);
                    else
                        add_op(msp_pkg::OP_TICK,
                               msp_pkg::reg_sel_t'($urandom_range(0, 7)), $urandom);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    d = $urandom;
                    if ($urandom_range(0, 1) != 0)
                        d[31:24] = msp_pkg::PASSWORD;
                    add_op(msp_pkg::opcode_t'($urandom_range(0, 3)),
                           msp_pkg::reg_sel_t'($urandom_range(0, 7)), d);
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_ops.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/msp_pkg.sv
hdl/mark_space_pwm_with_clock_divider.sv
tb/tb_mark_space_pwm_with_clock_divider.sv
